// ----- rtl/sbox_linear_approx_row_macros.svh -----
// Assertion macros shared by the sbox_linear_approx_row RTL
`ifndef SBOX_LINEAR_APPROX_ROW_MACROS_SVH
`define SBOX_LINEAR_APPROX_ROW_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SLA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define SLA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sla_pkg.sv -----
// Shared types and constants of the S-box linear approximation row block
package sla_pkg;

  localparam int SBOX_WIDTH_DEF = 4;
  localparam int MASK_W         = 4;
  localparam int BIAS_W         = 4;
  localparam int ENTRY_W        = 4;
  localparam int TABLE_W        = 64;

  localparam logic [TABLE_W-1:0] SBOX_RESET = 64'h7095C6A38BF21D4E;

  // One output-mask slot as issued by the sequencer
  typedef struct packed {
    logic              valid;
    logic              tail;   // final mask of the current input mask
    logic [MASK_W-1:0] x;
    logic [MASK_W-1:0] y;
  } slot_t;

  // Scored slot leaving the counting pipeline
  typedef struct packed {
    logic              valid;
    logic              tail;
    logic              qual;   // count above half: positive bias
    logic [MASK_W-1:0] y;
    logic [BIAS_W-1:0] bias;
  } score_t;

endpackage

// ----- rtl/sbox_linear_approx_row.sv -----
// Top level of the S-box linear approximation row block
//
//   channel   | handshake                  | payload
//   ----------+----------------------------+------------------------------------------
//   command   | start / busy               | in_mask
//   result    | result_valid (strobe)      | approx_mask, bias_sixteenths, found, last
//   config    | sbox_table_we              | sbox_table_wdata
//
// A command issues 2^SBOX_WIDTH - 1 output masks (15 at width 4), one output mask per cycle;
// busy drops on the last mask so the next command follows without a gap.
// A qualifying entry is held until the next qualifying mask or the row's tail is scored;
// a row's final result or empty-row marker follows the tail mask through the counting
// pipeline and the result stage.
// rst clears control state and loads the default S-box; the receiver cannot stall.

module sbox_linear_approx_row #(
  parameter int SBOX_WIDTH = sla_pkg::SBOX_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [sla_pkg::MASK_W-1:0]  in_mask,
  input  logic                        sbox_table_we,
  input  logic [sla_pkg::TABLE_W-1:0] sbox_table_wdata,
  output logic                        result_valid,
  output logic [sla_pkg::MASK_W-1:0]  approx_mask,
  output logic [sla_pkg::BIAS_W-1:0]  bias_sixteenths,
  output logic                        found,
  output logic                        last
);

  logic [sla_pkg::TABLE_W-1:0] sbox_table;
  sla_pkg::slot_t              slot;
  sla_pkg::score_t             score;

  always_ff @(posedge clk) begin
    if (rst) begin
      sbox_table <= sla_pkg::SBOX_RESET;
    end else if (sbox_table_we) begin
      sbox_table <= sbox_table_wdata;
    end
  end

  sla_seq #(
    .SBOX_WIDTH(SBOX_WIDTH)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .in_mask(in_mask),
    .busy   (busy),
    .slot   (slot)
  );

  sla_core #(
    .SBOX_WIDTH(SBOX_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .sbox_table(sbox_table),
    .slot      (slot),
    .score     (score)
  );

  sla_emit u_emit (
    .clk            (clk),
    .rst            (rst),
    .score          (score),
    .result_valid   (result_valid),
    .approx_mask    (approx_mask),
    .bias_sixteenths(bias_sixteenths),
    .found          (found),
    .last           (last)
  );

endmodule

// ----- rtl/sla_seq.sv -----
// Output-mask sequencer: steps y over 1..2^W-1 for each accepted input mask
`include "sbox_linear_approx_row_macros.svh"

module sla_seq #(
  parameter int SBOX_WIDTH = sla_pkg::SBOX_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [sla_pkg::MASK_W-1:0] in_mask,
  output logic                       busy,
  output sla_pkg::slot_t             slot
);

  localparam int MW = sla_pkg::MASK_W;
  localparam logic [MW-1:0] Y_FIRST = MW'(1);
  localparam logic [MW-1:0] Y_LAST  = MW'((1 << SBOX_WIDTH) - 1);

  logic          active;
  logic [MW-1:0] x;
  logic [MW-1:0] y;
  logic          accept;

  // the tail slot frees the sequencer, so the next mask follows without a gap
  assign busy   = active && (y != Y_LAST);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (accept) begin
      active <= 1'b1;
    end else if (active && (y == Y_LAST)) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x <= in_mask;
      y <= Y_FIRST;
    end else if (active && (y != Y_LAST)) begin
      y <= y + Y_FIRST;
    end
  end

  assign slot.valid = active;
  assign slot.tail  = active && (y == Y_LAST);
  assign slot.x     = x;
  assign slot.y     = y;

  `SLA_ASSERT_NEXT(a_first_slot, accept, slot.valid && (slot.y == Y_FIRST) && (slot.x == $past(in_mask)), "sla_seq: accepted mask did not start at y=1")
  `SLA_ASSERT_NEXT(a_slots_contiguous, slot.valid && !slot.tail, slot.valid && (slot.x == $past(slot.x)) && (slot.y == $past(slot.y) + Y_FIRST), "sla_seq: slot run broken before tail")

endmodule

// ----- rtl/sla_core.sv -----
// Counting pipeline: match bits, half popcounts, total and bias
module sla_core #(
  parameter int SBOX_WIDTH = sla_pkg::SBOX_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [sla_pkg::TABLE_W-1:0] sbox_table,
  input  sla_pkg::slot_t              slot,
  output sla_pkg::score_t             score
);

  localparam int W    = SBOX_WIDTH;
  localparam int T    = 1 << W;
  localparam int H    = T / 2;
  localparam int EW   = sla_pkg::ENTRY_W;
  localparam int BW   = sla_pkg::BIAS_W;
  localparam logic [W:0] HALF = (W + 1)'(H);

  // stage 1: one match bit per S-box input
  sla_pkg::slot_t s1;
  logic [T-1:0]   match_next;
  logic [T-1:0]   match;

  always_comb begin
    logic [W-1:0] idx;
    logic [W-1:0] ent;
    match_next = '0;
    for (int n = 0; n < T; n++) begin
      idx = W'(n);
      ent = sbox_table[n*EW +: W];
      match_next[n] = (^(idx & slot.x[W-1:0])) ~^ (^(ent & slot.y[W-1:0]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1.valid <= slot.valid;
    end
    s1.tail <= slot.tail;
    s1.x    <= slot.x;
    s1.y    <= slot.y;
    match   <= match_next;
  end

  // stage 2: popcount of each half
  sla_pkg::slot_t s2;
  logic [W-1:0]   cnt_lo_next, cnt_hi_next;
  logic [W-1:0]   cnt_lo, cnt_hi;

  always_comb begin
    cnt_lo_next = '0;
    cnt_hi_next = '0;
    for (int i = 0; i < H; i++) begin
      cnt_lo_next = cnt_lo_next + W'(match[i]);
      cnt_hi_next = cnt_hi_next + W'(match[H+i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else begin
      s2.valid <= s1.valid;
    end
    s2.tail <= s1.tail;
    s2.x    <= s1.x;
    s2.y    <= s1.y;
    cnt_lo  <= cnt_lo_next;
    cnt_hi  <= cnt_hi_next;
  end

  // stage 3: total, threshold, bias in sixteenths
  logic [W:0] total;
  logic [W:0] diff;

  assign total = {1'b0, cnt_lo} + {1'b0, cnt_hi};
  assign diff  = total - HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      score.valid <= 1'b0;
    end else begin
      score.valid <= s2.valid;
    end
    score.tail <= s2.tail;
    score.qual <= total > HALF;
    score.y    <= s2.y;
    // diff stays within W bits whenever the entry qualifies
    score.bias <= BW'(diff[W-1:0]) << (BW - W);
  end

endmodule

// ----- rtl/sla_emit.sv -----
// Result stage: holds one qualifying entry back to mark the last of a row
`include "sbox_linear_approx_row_macros.svh"

module sla_emit (
  input  logic                       clk,
  input  logic                       rst,
  input  sla_pkg::score_t            score,
  output logic                       result_valid,
  output logic [sla_pkg::MASK_W-1:0] approx_mask,
  output logic [sla_pkg::BIAS_W-1:0] bias_sixteenths,
  output logic                       found,
  output logic                       last
);

  localparam int MW = sla_pkg::MASK_W;
  localparam int BW = sla_pkg::BIAS_W;

  logic          hold_valid, hold_final;
  logic [MW-1:0] hold_y;
  logic [BW-1:0] hold_bias;

  logic          hold_valid_next, hold_final_next;
  logic [MW-1:0] hold_y_next;
  logic [BW-1:0] hold_bias_next;

  logic          emit;
  logic [MW-1:0] emit_y;
  logic [BW-1:0] emit_bias;
  logic          emit_found, emit_last;

  always_comb begin
    hold_valid_next = hold_valid;
    hold_final_next = hold_final;
    hold_y_next     = hold_y;
    hold_bias_next  = hold_bias;
    emit            = 1'b0;
    emit_y          = hold_y;
    emit_bias       = hold_bias;
    emit_found      = 1'b1;
    emit_last       = 1'b0;

    if (hold_valid && hold_final) begin
      // tail entry of the previous row; the incoming slot opens a new row
      emit            = 1'b1;
      emit_last       = 1'b1;
      hold_valid_next = score.valid && score.qual;
      hold_final_next = score.tail;
      hold_y_next     = score.y;
      hold_bias_next  = score.bias;
    end else if (score.valid && score.qual) begin
      emit            = hold_valid;
      hold_valid_next = 1'b1;
      hold_final_next = score.tail;
      hold_y_next     = score.y;
      hold_bias_next  = score.bias;
    end else if (score.valid && score.tail) begin
      emit            = 1'b1;
      emit_last       = 1'b1;
      hold_valid_next = 1'b0;
      hold_final_next = 1'b0;
      if (!hold_valid) begin
        // empty row marker
        emit_y     = '0;
        emit_bias  = '0;
        emit_found = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid   <= 1'b0;
      hold_final   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      hold_valid   <= hold_valid_next;
      hold_final   <= hold_final_next;
      result_valid <= emit;
    end
    hold_y          <= hold_y_next;
    hold_bias       <= hold_bias_next;
    approx_mask     <= emit_y;
    bias_sixteenths <= emit_bias;
    found           <= emit_found;
    last            <= emit_last;
  end

  `SLA_ASSERT_NEXT(a_final_flushes, hold_valid && hold_final, result_valid && last && found, "sla_emit: held tail entry not sent")
  `SLA_ASSERT_IMPL(a_empty_is_last, result_valid && !found, last && (approx_mask == '0), "sla_emit: malformed empty row marker")

endmodule

// ----- verif/sbox_linear_approx_row_tb.sv -----
// Testbench for sbox_linear_approx_row: directed table plus random masks, checked against a predictor
`timescale 1ns / 100ps

module sbox_linear_approx_row_tb;

  // One row entry of the linear approximation table as the block reports it
  typedef struct packed {
    logic [sla_pkg::MASK_W-1:0] approx_mask;
    logic [sla_pkg::BIAS_W-1:0] bias;
    logic                       found;
    logic                       last;
  } lat_entry_t;

  typedef struct packed {
    bit                          cfg_we;
    logic [sla_pkg::TABLE_W-1:0] cfg;
    logic [sla_pkg::MASK_W-1:0]  mask;
    bit                          typed;
    lat_entry_t                  res;
  } dir_row_t;

  localparam logic [sla_pkg::TABLE_W-1:0] SBOX_IDENT = 64'hFEDCBA9876543210;
  localparam logic [sla_pkg::TABLE_W-1:0] SBOX_ZERO  = 64'h0;
  localparam logic [sla_pkg::TABLE_W-1:0] SBOX_ONES  = 64'hFFFFFFFFFFFFFFFF;
  localparam lat_entry_t EMPTY_ROW = '{approx_mask: 4'h0, bias: 4'h0, found: 1'b0, last: 1'b1};
  localparam lat_entry_t NO_RES    = '{approx_mask: 4'h0, bias: 4'h0, found: 1'b0, last: 1'b0};
  localparam int N_DIR = 17;
  localparam int N_PHASES = 5;
  localparam int PHASE_ITEMS = 70;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic [sla_pkg::MASK_W-1:0]   in_mask = '0;
  logic                         sbox_table_we = 1'b0;
  logic [sla_pkg::TABLE_W-1:0]  sbox_table_wdata = '0;
  logic                         busy;
  logic                         result_valid;
  logic [sla_pkg::MASK_W-1:0]   approx_mask;
  logic [sla_pkg::BIAS_W-1:0]   bias_sixteenths;
  logic                         found;
  logic                         last;

  lat_entry_t                   lat_expect_q[$];
  logic [sla_pkg::TABLE_W-1:0]  sbox_cur = sla_pkg::SBOX_RESET;
  int                           mismatch_cnt = 0;

  // Directed rows: typed results only where the S-box makes them obvious
  dir_row_t dir_tab [N_DIR] = '{
    '{1'b1, sla_pkg::SBOX_RESET, 4'h1, 1'b0, NO_RES},
    '{1'b0, sla_pkg::SBOX_RESET, 4'h2, 1'b0, NO_RES},
    '{1'b0, sla_pkg::SBOX_RESET, 4'h4, 1'b0, NO_RES},
    '{1'b0, sla_pkg::SBOX_RESET, 4'h8, 1'b0, NO_RES},
    '{1'b0, sla_pkg::SBOX_RESET, 4'hF, 1'b0, NO_RES},
    '{1'b0, sla_pkg::SBOX_RESET, 4'h0, 1'b1, EMPTY_ROW},   // zero mask, bijective box
    '{1'b1, SBOX_IDENT, 4'h1, 1'b1, '{4'h1, 4'h8, 1'b1, 1'b1}},
    '{1'b0, SBOX_IDENT, 4'h6, 1'b1, '{4'h6, 4'h8, 1'b1, 1'b1}},
    '{1'b0, SBOX_IDENT, 4'h9, 1'b1, '{4'h9, 4'h8, 1'b1, 1'b1}},
    '{1'b0, SBOX_IDENT, 4'hF, 1'b1, '{4'hF, 4'h8, 1'b1, 1'b1}},
    '{1'b0, SBOX_IDENT, 4'h0, 1'b1, EMPTY_ROW},
    '{1'b1, SBOX_ZERO,  4'hF, 1'b1, EMPTY_ROW},
    '{1'b0, SBOX_ZERO,  4'hA, 1'b1, EMPTY_ROW},
    '{1'b0, SBOX_ZERO,  4'h0, 1'b0, NO_RES},      // full row, all biases maximal
    '{1'b1, SBOX_ONES,  4'h5, 1'b1, EMPTY_ROW},
    '{1'b0, SBOX_ONES,  4'h0, 1'b0, NO_RES},
    '{1'b1, sla_pkg::SBOX_RESET, 4'h7, 1'b0, NO_RES}
  };

  sbox_linear_approx_row dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .in_mask          (in_mask),
    .sbox_table_we    (sbox_table_we),
    .sbox_table_wdata (sbox_table_wdata),
    .result_valid     (result_valid),
    .approx_mask      (approx_mask),
    .bias_sixteenths  (bias_sixteenths),
    .found            (found),
    .last             (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

  // Queue the table row entries for input mask x under S-box tbl
  function automatic void predict_lat_row(input logic [sla_pkg::TABLE_W-1:0] tbl,
                                          input logic [sla_pkg::MASK_W-1:0] x);
    int hits;
    int n_out;
    logic [3:0] s;
    logic [3:0] num;
    lat_entry_t e;
    n_out = 0;
    for (int y = 1; y < 16; y++) begin
      hits = 0;
      for (int i = 0; i < 16; i++) begin
        num = i[3:0];
        s = tbl[i*4 +: 4];
        if ((^(num & x)) == (^(s & y[3:0])))
          hits++;
      end
      if (hits > 8) begin
        e.approx_mask = y[3:0];
        e.bias = 4'(hits - 8);
        e.found = 1'b1;
        e.last = 1'b0;
        lat_expect_q.push_back(e);
        n_out++;
      end
    end
    if (n_out == 0)
      lat_expect_q.push_back(EMPTY_ROW);
    else
      lat_expect_q[lat_expect_q.size()-1].last = 1'b1;
  endfunction

  function automatic logic [sla_pkg::TABLE_W-1:0] random_perm_box();
    logic [3:0] p [16];
    logic [3:0] t;
    logic [sla_pkg::TABLE_W-1:0] v;
    int j;
    for (int i = 0; i < 16; i++)
      p[i] = i[3:0];
    for (int i = 15; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = p[i];
      p[i] = p[j];
      p[j] = t;
    end
    for (int i = 0; i < 16; i++)
      v[i*4 +: 4] = p[i];
    return v;
  endfunction

  // Leaves start high after the transfer; the next call decides whether it drops
  task automatic send_mask(input logic [sla_pkg::MASK_W-1:0] m, input int gap,
                           input bit typed, input lat_entry_t tres);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_mask <= m;
    do @(posedge clk); while (busy);
    if (typed)
      lat_expect_q.push_back(tres);
    else
      predict_lat_row(sbox_cur, m);
  endtask

  task automatic drain_rows();
    start <= 1'b0;
    while (lat_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_sbox(input logic [sla_pkg::TABLE_W-1:0] v);
    drain_rows();
    sbox_table_we <= 1'b1;
    sbox_table_wdata <= v;
    @(posedge clk);
    sbox_table_we <= 1'b0;
    sbox_cur = v;
  endtask

  always @(posedge clk) begin
    lat_entry_t e;
    if (!rst && result_valid) begin
      if (lat_expect_q.size() == 0) begin
        $error("unexpected result: approx_mask %0h bias %0d found %0b last %0b",
               approx_mask, bias_sixteenths, found, last);
        mismatch_cnt++;
      end else begin
        e = lat_expect_q.pop_front();
        if (approx_mask !== e.approx_mask) begin
          $error("approx_mask: expected %0h, actual %0h", e.approx_mask, approx_mask);
          mismatch_cnt++;
        end
        if (bias_sixteenths !== e.bias) begin
          $error("bias_sixteenths: expected %0d, actual %0d", e.bias, bias_sixteenths);
          mismatch_cnt++;
        end
        if (found !== e.found) begin
          $error("found: expected %0b, actual %0b", e.found, found);
          mismatch_cnt++;
        end
        if (last !== e.last) begin
          $error("last: expected %0b, actual %0b", e.last, last);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    logic [sla_pkg::TABLE_W-1:0] box;
    logic [sla_pkg::MASK_W-1:0] m;
    bit burst;
    int gap;
    burst = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].cfg_we)
        write_sbox(dir_tab[i].cfg);
      send_mask(dir_tab[i].mask, $urandom_range(0, 9), dir_tab[i].typed, dir_tab[i].res);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0, 3: box = random_perm_box();
        1: box = {$urandom, $urandom};
        2: begin
          for (int i = 0; i < 16; i++)
            box[i*4 +: 4] = ($urandom_range(0, 1) != 0) ? 4'hF : 4'h0;
        end
        default: box = sla_pkg::SBOX_RESET;
      endcase
      write_sbox(box);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // sender holds off until the block has emptied out
        if (k == PHASE_ITEMS / 2)
          drain_rows();
        if ($urandom_range(0, 15) == 0)
          burst = !burst;
        gap = burst ? 0 : $urandom_range(0, 9);
        m = ($urandom_range(0, 19) == 0) ? 4'h0 : 4'($urandom_range(1, 15));
        send_mask(m, gap, 1'b0, NO_RES);
      end
    end

    drain_rows();
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
